// ----- src/arp_request_responder_defines.svh -----
// Assertion macros for the ARP request responder.
`ifndef ARP_REQUEST_RESPONDER_DEFINES_SVH
`define ARP_REQUEST_RESPONDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ARPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ARPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/arpr_pkg.sv -----
// Shared types, constants and helpers of the ARP request responder.
package arpr_pkg;

  localparam int unsigned FRAME_LEN = 42;
  localparam int unsigned ADDR_W    = $clog2(FRAME_LEN);
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CHECK_LEN = 22;
  localparam int unsigned CHECK_W   = $clog2(CHECK_LEN);
  localparam int unsigned RANK_W    = 25;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 6'd63;
  localparam logic [CNT_W-1:0]  LAST_IDX  = 6'(FRAME_LEN - 1);
  localparam logic [ADDR_W-1:0] RANK_B0   = 6'd39;
  localparam logic [ADDR_W-1:0] RANK_B1   = 6'd40;
  localparam logic [ADDR_W-1:0] RANK_B2   = 6'd41;

  // Expected request bytes: broadcast dst, type 0806, ARP request header.
  localparam logic [7:0] REQ_EXPECT [CHECK_LEN] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h06,
    8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };
  // Positions that take part in the check (source MAC is ignored).
  localparam logic [CHECK_LEN-1:0] CHECK_CARE = 22'h3ff03f;

  localparam logic [7:0] REPLY_HDR [8] = '{
    8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  typedef struct packed {
    logic        frame_held;
    logic        is_request;
    logic [23:0] ip_low;
  } frame_status_t;

  // Store address that feeds reply byte k (don't care for generated bytes).
  function automatic logic [ADDR_W-1:0] src_addr(input logic [CNT_W-1:0] k);
    logic [ADDR_W-1:0] a;
    a = '0;
    case (k) inside
      [6'd0:6'd5]:            a = k + 6'd6;
      6'd6, 6'd7, 6'd12, 6'd13: a = k;
      6'd22, 6'd23:           a = k - 6'd16;
      [6'd28:6'd31]:          a = k + 6'd10;
      [6'd32:6'd41]:          a = k - 6'd10;
      default:                a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/arpr_stream_if.sv -----
// Valid/ready stream interfaces for frame bytes in and reply words out.
interface arpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface arpr_out_if;
  logic                             valid;
  logic                             ready;
  logic [7:0]                       out_byte;
  logic                             is_reply;
  logic signed [arpr_pkg::RANK_W-1:0] queried_rank;
  logic                             out_last;

  modport source (output valid, output out_byte, output is_reply,
                  output queried_rank, output out_last, input ready);
  modport sink   (input valid, input out_byte, input is_reply,
                  input queried_rank, input out_last, output ready);
endinterface

// ----- src/arp_request_responder.sv -----
// ARP request responder: takes a frame a byte per word, answers with reply or reject.
// Frame bytes are taken back to back, one word per cycle, between frames.
// After the last byte, input ready stays low until the reply or reject has been issued.
// First word passes hold, run, read and output registers, then one word per ready cycle,
// set by the single frame store read port feeding the output register.
// Synchronous active-low reset clears count and control; the frame store is not cleared.
module arp_request_responder (
  input  logic        clk,
  input  logic        rst_n,
  arpr_in_if.sink     in_ch,
  arpr_out_if.source  out_ch
);

  logic                            wr_en;
  logic [arpr_pkg::ADDR_W-1:0]     wr_addr;
  logic [7:0]                      wr_data;
  logic                            rd_en;
  logic [arpr_pkg::ADDR_W-1:0]     rd_addr;
  logic [7:0]                      rd_data_r;
  logic                            release_frame;
  arpr_pkg::frame_status_t         status;

  arpr_rx u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .release_frame (release_frame),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .status        (status)
  );

  arpr_frame_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  arpr_tx u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .status        (status),
    .release_frame (release_frame),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data_r     (rd_data_r),
    .out_ch        (out_ch)
  );

endmodule

// ----- src/arpr_frame_ram.sv -----
// Frame store: one write port, one registered read port.
module arpr_frame_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [arpr_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [arpr_pkg::ADDR_W-1:0]   rd_addr,
  output logic [7:0]                    rd_data_r
);

  logic [7:0] mem [arpr_pkg::FRAME_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- src/arpr_rx.sv -----
// Receive side: byte count, store writes, header match flags, target IP capture.
module arpr_rx (
  input  logic                            clk,
  input  logic                            rst_n,
  arpr_in_if.sink                         in_ch,
  input  logic                            release_frame,
  output logic                            wr_en,
  output logic [arpr_pkg::ADDR_W-1:0]     wr_addr,
  output logic [7:0]                      wr_data,
  output arpr_pkg::frame_status_t         status
);

  logic [arpr_pkg::CNT_W-1:0]     count_r;
  logic                           held_r;
  logic                           len_ok_r;
  logic [arpr_pkg::CHECK_LEN-1:0] match_r;
  logic [7:0]                     ip2_r, ip1_r, ip0_r;
  logic                           accept;

  assign in_ch.ready = !held_r;
  assign accept      = in_ch.valid && !held_r;

  assign wr_en   = accept && (count_r < arpr_pkg::CNT_W'(arpr_pkg::FRAME_LEN));
  assign wr_addr = count_r[arpr_pkg::ADDR_W-1:0];
  assign wr_data = in_ch.in_byte;

  assign status.frame_held = held_r;
  assign status.is_request = len_ok_r && (&(match_r | ~arpr_pkg::CHECK_CARE));
  assign status.ip_low     = {ip2_r, ip1_r, ip0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      held_r  <= 1'b0;
    end else begin
      if (accept) begin
        if (in_ch.in_last) begin
          count_r <= '0;
          held_r  <= 1'b1;
        end else if (count_r < arpr_pkg::COUNT_MAX) begin
          count_r <= count_r + 6'd1;
        end
      end else if (release_frame) begin
        held_r <= 1'b0;
      end
    end
  end

  // Per-frame capture; a short frame is rejected so stale flags never matter.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_ch.in_last) begin
        len_ok_r <= (count_r >= arpr_pkg::LAST_IDX);
      end
      if (count_r < arpr_pkg::CNT_W'(arpr_pkg::CHECK_LEN)) begin
        match_r[count_r[arpr_pkg::CHECK_W-1:0]] <=
          (in_ch.in_byte == arpr_pkg::REQ_EXPECT[count_r[arpr_pkg::CHECK_W-1:0]]);
      end
      if (count_r == arpr_pkg::RANK_B0) ip2_r <= in_ch.in_byte;
      if (count_r == arpr_pkg::RANK_B1) ip1_r <= in_ch.in_byte;
      if (count_r == arpr_pkg::RANK_B2) ip0_r <= in_ch.in_byte;
    end
  end

endmodule

// ----- src/arpr_tx.sv -----
// Transmit side: reply sequencer, store read stage and output register.
`include "arp_request_responder_defines.svh"

module arpr_tx (
  input  logic                            clk,
  input  logic                            rst_n,
  input  arpr_pkg::frame_status_t         status,
  output logic                            release_frame,
  output logic                            rd_en,
  output logic [arpr_pkg::ADDR_W-1:0]     rd_addr,
  input  logic [7:0]                      rd_data_r,
  arpr_out_if.source                      out_ch
);

  logic                                running_r;
  logic                                run_reply_r;
  logic [arpr_pkg::CNT_W-1:0]          k_r;
  logic signed [arpr_pkg::RANK_W-1:0]  rank_r;
  logic                                s1_valid_r;
  logic                                s1_rej_r;
  logic [arpr_pkg::CNT_W-1:0]          s1_k_r;
  logic signed [arpr_pkg::RANK_W-1:0]  s1_rank_r;
  logic                                out_valid_r;
  logic [7:0]                          out_byte_r;
  logic                                out_reply_r;
  logic signed [arpr_pkg::RANK_W-1:0]  out_rank_r;
  logic                                out_last_r;

  logic       adv;
  logic       issue;
  logic       start;
  logic [7:0] byte_nxt;
  logic [5:0] hdr_off;

  assign adv           = !out_valid_r || out_ch.ready;
  assign issue         = running_r && adv;
  assign start         = !running_r && status.frame_held;
  assign release_frame = issue && (!run_reply_r || (k_r == arpr_pkg::LAST_IDX));
  assign rd_en         = adv;
  assign rd_addr       = arpr_pkg::src_addr(k_r);
  assign hdr_off       = s1_k_r - 6'd14;

  // rank travels with the read stage; the next frame may reload rank_r under a stall
  always_comb begin
    byte_nxt = rd_data_r;
    case (s1_k_r) inside
      6'd8, 6'd24:   byte_nxt = {8{s1_rank_r[arpr_pkg::RANK_W-1]}};
      6'd9, 6'd25:   byte_nxt = s1_rank_r[23:16];
      6'd10, 6'd26:  byte_nxt = s1_rank_r[15:8];
      6'd11, 6'd27:  byte_nxt = s1_rank_r[7:0];
      [6'd14:6'd21]: byte_nxt = arpr_pkg::REPLY_HDR[hdr_off[2:0]];
      default:       byte_nxt = rd_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        running_r <= 1'b1;
      end else if (release_frame) begin
        running_r <= 1'b0;
      end
      if (adv) begin
        s1_valid_r  <= issue;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      run_reply_r <= status.is_request;
      k_r         <= '0;
      rank_r      <= $signed({1'b0, status.ip_low}) - 25'sd1;
    end else if (issue) begin
      k_r <= k_r + 6'd1;
    end
    if (adv) begin
      s1_k_r    <= k_r;
      s1_rej_r  <= !run_reply_r;
      s1_rank_r <= rank_r;
      if (s1_rej_r) begin
        out_byte_r  <= '0;
        out_reply_r <= 1'b0;
        out_rank_r  <= '0;
        out_last_r  <= 1'b1;
      end else begin
        out_byte_r  <= byte_nxt;
        out_reply_r <= 1'b1;
        out_rank_r  <= s1_rank_r;
        out_last_r  <= (s1_k_r == arpr_pkg::LAST_IDX);
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.is_reply     = out_reply_r;
  assign out_ch.queried_rank = out_rank_r;
  assign out_ch.out_last     = out_last_r;

  `ARPR_ASSERT_NOW(a_run_needs_frame, running_r, status.frame_held,
    "sequencer running with no frame held")
  `ARPR_ASSERT_NOW(a_reject_single, out_valid_r && !out_reply_r, out_last_r,
    "reject word not marked last")
  `ARPR_ASSERT_NEXT(a_release_stops, release_frame, !running_r && !status.frame_held,
    "sequencer or frame hold survived release")
  `ARPR_ASSERT_NOW(a_index_range, s1_valid_r && !s1_rej_r, s1_k_r <= arpr_pkg::LAST_IDX,
    "reply index past end of frame")

endmodule

// ----- sim/tb_arp_request_responder.sv -----
// Self-checking testbench for the ARP request responder: directed and random frames.
module tb_arp_request_responder;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0]                         data;
    logic                               is_reply;
    logic signed [arpr_pkg::RANK_W-1:0] rank;
    logic                               last;
  } reply_word_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_RUNS} rx_mode_t;

  localparam int unsigned ARP_LEN   = 42;
  localparam int unsigned CNT_SAT   = 63;
  localparam logic [7:0] REQUEST_HDR [8] = '{
    8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };
  localparam logic [7:0] ARP_REPLY_HDR [8] = '{
    8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  logic clk;
  logic rst_n;

  arpr_in_if  in_ch ();
  arpr_out_if out_ch ();

  arp_request_responder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [7:0]  frame_mem [ARP_LEN];
  logic [5:0]  rx_byte_cnt;
  reply_word_t pending_words [$];

  int errors;
  int frames_sent;
  int replies_seen;
  int rejects_seen;

  // stimulus pacing
  bit       tx_bursty;
  int       burst_left;
  rx_mode_t rx_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Broadcast ARP request, truncated or padded with random bytes to len.
  function automatic byte_q_t make_request(input logic [47:0] smac, input logic [47:0] sha,
                                           input logic [31:0] spa, input logic [47:0] tha,
                                           input logic [31:0] tpa, input int len);
    byte_q_t f;
    for (int i = 0; i < 6; i++) f.push_back(8'hff);
    for (int i = 5; i >= 0; i--) f.push_back(smac[8*i +: 8]);
    f.push_back(8'h08);
    f.push_back(8'h06);
    for (int i = 0; i < 8; i++) f.push_back(REQUEST_HDR[i]);
    for (int i = 5; i >= 0; i--) f.push_back(sha[8*i +: 8]);
    for (int i = 3; i >= 0; i--) f.push_back(spa[8*i +: 8]);
    for (int i = 5; i >= 0; i--) f.push_back(tha[8*i +: 8]);
    for (int i = 3; i >= 0; i--) f.push_back(tpa[8*i +: 8]);
    while (f.size() < len) f.push_back(8'($urandom()));
    while (f.size() > len) void'(f.pop_back());
    return f;
  endfunction

  function automatic byte_q_t rand_request(input logic [23:0] ip_low, input int len);
    return make_request(rand48(), rand48(), $urandom(), rand48(),
                        {8'($urandom()), ip_low}, len);
  endfunction

  // Track one accepted frame byte; on the last byte queue the reply or reject words.
  task automatic predict_word(input logic [7:0] b, input logic last);
    logic [7:0]  rep [ARP_LEN];
    logic [31:0] rank;
    logic        ok;
    int          len;
    reply_word_t w;
    if (rx_byte_cnt < ARP_LEN) frame_mem[rx_byte_cnt] = b;
    if (rx_byte_cnt < CNT_SAT) rx_byte_cnt = rx_byte_cnt + 6'd1;
    if (!last) return;
    len = rx_byte_cnt;
    rx_byte_cnt = '0;
    ok = (len >= ARP_LEN);
    if (ok) begin
      for (int i = 0; i < 6; i++) if (frame_mem[i] != 8'hff) ok = 1'b0;
      if (frame_mem[12] != 8'h08 || frame_mem[13] != 8'h06) ok = 1'b0;
      for (int i = 0; i < 8; i++) if (frame_mem[14+i] != REQUEST_HDR[i]) ok = 1'b0;
    end
    if (!ok) begin
      w = '{data: 8'h00, is_reply: 1'b0, rank: '0, last: 1'b1};
      pending_words.push_back(w);
      return;
    end
    rank = {8'h00, frame_mem[39], frame_mem[40], frame_mem[41]} - 32'd1;
    for (int i = 0; i < 6; i++) rep[i] = frame_mem[6+i];
    rep[6]  = frame_mem[6];
    rep[7]  = frame_mem[7];
    rep[8]  = rank[31:24];
    rep[9]  = rank[23:16];
    rep[10] = rank[15:8];
    rep[11] = rank[7:0];
    rep[12] = frame_mem[12];
    rep[13] = frame_mem[13];
    for (int i = 0; i < 8; i++)  rep[14+i] = ARP_REPLY_HDR[i];
    for (int i = 0; i < 6; i++)  rep[22+i] = rep[6+i];
    for (int i = 0; i < 4; i++)  rep[28+i] = frame_mem[38+i];
    for (int i = 0; i < 6; i++)  rep[32+i] = frame_mem[22+i];
    for (int i = 0; i < 4; i++)  rep[38+i] = frame_mem[28+i];
    for (int k = 0; k < ARP_LEN; k++) begin
      w = '{data: rep[k], is_reply: 1'b1, rank: rank[arpr_pkg::RANK_W-1:0],
            last: (k == ARP_LEN - 1)};
      pending_words.push_back(w);
    end
  endtask

  // Valid stays up after a handshake; the next word or a drop of valid follows in the same step.
  task automatic send_word(input logic [7:0] b, input logic last);
    if (tx_bursty) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(b, last);
  endtask

  task automatic send_frame(input byte_q_t f);
    for (int i = 0; i < f.size(); i++) send_word(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  task automatic check_word();
    reply_word_t w;
    if (pending_words.size() == 0) begin
      errors++;
      $display("%0t unexpected word: expected none, actual byte %02h reply %0b last %0b",
               $time, out_ch.out_byte, out_ch.is_reply, out_ch.out_last);
      return;
    end
    w = pending_words.pop_front();
    if (out_ch.out_last === 1'b1) begin
      if (out_ch.is_reply === 1'b1) replies_seen++;
      else rejects_seen++;
    end
    if (out_ch.out_byte !== w.data) begin
      errors++;
      $display("%0t out_byte: expected %02h, actual %02h", $time, w.data, out_ch.out_byte);
    end
    if (out_ch.is_reply !== w.is_reply) begin
      errors++;
      $display("%0t is_reply: expected %0b, actual %0b", $time, w.is_reply, out_ch.is_reply);
    end
    if (out_ch.queried_rank !== w.rank) begin
      errors++;
      $display("%0t queried_rank: expected %0d, actual %0d", $time, w.rank,
               out_ch.queried_rank);
    end
    if (out_ch.out_last !== w.last) begin
      errors++;
      $display("%0t out_last: expected %0b, actual %0b", $time, w.last, out_ch.out_last);
    end
  endtask

  // Result side: check on handshake, then pick next ready level.
  initial begin : rx_side
    int  run_left;
    logic level;
    run_left = 0;
    level    = 1'b1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_word();
      case (rx_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            level    = ~level;
            run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 8);
          end
          run_left--;
          out_ch.ready <= level;
        end
      endcase
    end
  end

  task automatic test_valid_requests();
    tx_bursty = 0;
    rx_mode   = RX_ALWAYS;
    // full length first so every store entry is written before any short frame
    send_frame(rand_request(24'h000000, CNT_SAT + 1));  // rank -1, count reaches its maximum
    tx_bursty = 1;
    rx_mode   = RX_RUNS;
    send_frame(rand_request(24'hffffff, ARP_LEN));      // top rank
  endtask

  task automatic test_rejects();
    byte_q_t f;
    int      pos;
    tx_bursty = 0;
    // lone byte right behind a reply that may still be draining
    f = {8'hff};
    send_frame(f);
    rx_mode = RX_RANDOM;
    // one corrupted byte among destination, type and ARP header
    f   = rand_request(24'($urandom()), ARP_LEN);
    pos = $urandom_range(0, 15);
    pos = (pos < 6) ? pos : pos + 6;
    f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
    send_frame(f);
  endtask

  task automatic drain();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_words.size() != 0) begin
      errors++;
      $display("%0t leftover words: expected 0, actual %0d", $time, pending_words.size());
    end
  endtask

  initial begin
    errors       = 0;
    frames_sent  = 0;
    replies_seen = 0;
    rejects_seen = 0;
    rx_byte_cnt  = '0;
    tx_bursty    = 0;
    burst_left   = 0;
    rx_mode      = RX_ALWAYS;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_valid_requests();
    test_rejects();
    drain();

    $display("Sent %0d frames: %0d replies and %0d rejects checked word by word,",
             frames_sent, replies_seen, rejects_seen);
    $display("with rank extremes, count saturation, a lone byte and a bad header byte.");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/arpr_pkg.sv
src/arpr_stream_if.sv
src/arpr_frame_ram.sv
src/arpr_rx.sv
src/arpr_tx.sv
src/arp_request_responder.sv
sim/tb_arp_request_responder.sv
